FILE: rtl/dq_pkg.sv
// shared types, op and status codes and index helpers for the deque ring buffer
// no dependencies; imported by dq_store, dq_ctrl and double_ended_queue_unit
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DATA_W-1:0] data_t;

  localparam cnt_t DEPTH_CNT = CNT_W'(DEPTH);
  localparam idx_t IDX_ONE   = IDX_W'(1);
  localparam idx_t IDX_LAST  = IDX_W'(DEPTH - 1);

  // operation codes of the func field
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_DROP_FRONT = 3'd2;
  localparam logic [2:0] OP_DROP_BACK  = 3'd3;
  localparam logic [2:0] OP_DUMP_FWD   = 3'd4;
  localparam logic [2:0] OP_DUMP_BWD   = 3'd5;

  // status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]          func;
    logic signed [31:0]  value;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0]  element;
    logic [1:0]          status;
    logic                final_res;
  } out_beat_t;

  // one write port and one read port into the element store
  typedef struct packed {
    logic   we;
    idx_t   waddr;
    data_t  wdata;
    logic   re;
    idx_t   raddr;
  } mem_req_t;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } dq_state_t;

  // ring index add, both operands below DEPTH so one compare and subtract wraps it
  function automatic idx_t wrap_add(idx_t a, idx_t b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IDX_W + 1)'(DEPTH)) begin
      s = s - (IDX_W + 1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/dq_store.sv
// element store of the deque: synchronous ram, one write and one read port
// depends on dq_pkg for sizes and the request struct
`timescale 1ns / 1ps
`default_nettype none

module dq_store (
  input  wire logic             clk,
  input  wire dq_pkg::mem_req_t mem_req,
  output      dq_pkg::data_t    rd_data
);
  import dq_pkg::*;

  data_t mem_r [DEPTH];
  data_t rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem_r[mem_req.waddr] <= mem_req.wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (mem_req.re) begin
      rd_data_r <= mem_r[mem_req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: rtl/dq_ctrl.sv
// deque control: front index, occupancy, op decode and the dump sequencer
// depends on dq_pkg; drives dq_store and feeds the output register in the top level
`timescale 1ns / 1ps
`default_nettype none

module dq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire dq_pkg::in_beat_t  in_beat,
  output      logic              res_valid,
  output      dq_pkg::out_beat_t res_beat,
  input  wire logic              res_hold,
  output      dq_pkg::mem_req_t  mem_req,
  input  wire dq_pkg::data_t     mem_rd_data
);
  import dq_pkg::*;

  dq_state_t state_r, state_nxt;
  idx_t      front_r, front_nxt;
  cnt_t      occ_r, occ_nxt;
  logic      pend_r, pend_nxt;
  idx_t      dump_addr_r, dump_addr_nxt;
  cnt_t      dump_left_r, dump_left_nxt;
  logic      dump_bwd_r, dump_bwd_nxt;

  logic  in_take;
  logic  is_dump;
  logic  start_dump;
  logic  full;
  logic  empty;
  cnt_t  occ_m1;
  idx_t  first_addr;
  idx_t  next_addr;
  idx_t  push_front_addr;

  assign in_stall   = (state_r != S_IDLE) || res_hold;
  assign in_take    = in_valid && !in_stall;
  assign is_dump    = (in_beat.func == OP_DUMP_FWD) || (in_beat.func == OP_DUMP_BWD);
  assign full       = (occ_r >= DEPTH_CNT);
  assign empty      = (occ_r == '0);
  assign start_dump = in_take && is_dump && !empty;
  assign occ_m1     = occ_r - cnt_t'(1);

  assign push_front_addr = wrap_add(front_r, IDX_LAST);
  assign first_addr = (in_beat.func == OP_DUMP_BWD) ?
                      wrap_add(front_r, occ_m1[IDX_W-1:0]) : front_r;
  assign next_addr  = dump_bwd_r ? wrap_add(dump_addr_r, IDX_LAST) :
                      wrap_add(dump_addr_r, IDX_ONE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start_dump) begin
          state_nxt = S_DUMP;
        end
      end
      S_DUMP: begin
        if (pend_r && !res_hold && (dump_left_r == '0)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    res_valid     = 1'b0;
    res_beat      = '0;
    mem_req       = '0;
    front_nxt     = front_r;
    occ_nxt       = occ_r;
    pend_nxt      = pend_r;
    dump_addr_nxt = dump_addr_r;
    dump_left_nxt = dump_left_r;
    dump_bwd_nxt  = dump_bwd_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          res_valid          = 1'b1;
          res_beat.final_res = 1'b1;
          res_beat.status    = STAT_OK;
          case (in_beat.func) inside
            OP_PUSH_FRONT: begin
              if (full) begin
                res_beat.status = STAT_FULL;
              end else begin
                front_nxt     = push_front_addr;
                mem_req.we    = 1'b1;
                mem_req.waddr = push_front_addr;
                mem_req.wdata = in_beat.value;
                occ_nxt       = occ_r + cnt_t'(1);
              end
            end
            OP_PUSH_BACK: begin
              if (full) begin
                res_beat.status = STAT_FULL;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = wrap_add(front_r, occ_r[IDX_W-1:0]);
                mem_req.wdata = in_beat.value;
                occ_nxt       = occ_r + cnt_t'(1);
              end
            end
            OP_DROP_FRONT: begin
              if (empty) begin
                res_beat.status = STAT_EMPTY;
              end else begin
                front_nxt = wrap_add(front_r, IDX_ONE);
                occ_nxt   = occ_m1;
              end
            end
            OP_DROP_BACK: begin
              if (empty) begin
                res_beat.status = STAT_EMPTY;
              end else begin
                occ_nxt = occ_m1;
              end
            end
            OP_DUMP_FWD, OP_DUMP_BWD: begin
              if (empty) begin
                res_beat.status = STAT_EMPTY;
              end else begin
                // first element is read now, its beat goes out next cycle
                res_valid     = 1'b0;
                mem_req.re    = 1'b1;
                mem_req.raddr = first_addr;
                dump_addr_nxt = first_addr;
                dump_left_nxt = occ_m1;
                dump_bwd_nxt  = (in_beat.func == OP_DUMP_BWD);
                pend_nxt      = 1'b1;
              end
            end
            default: begin
              res_beat.status = STAT_OK;
            end
          endcase
        end
      end
      S_DUMP: begin
        res_valid          = pend_r;
        res_beat.element   = mem_rd_data;
        res_beat.status    = STAT_OK;
        res_beat.final_res = (dump_left_r == '0);
        if (pend_r && !res_hold) begin
          if (dump_left_r == '0) begin
            pend_nxt = 1'b0;
          end else begin
            mem_req.re    = 1'b1;
            mem_req.raddr = next_addr;
            dump_addr_nxt = next_addr;
            dump_left_nxt = dump_left_r - cnt_t'(1);
          end
        end
      end
      default: begin
        pend_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      front_r <= '0;
      occ_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      occ_r   <= occ_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dump_addr_r <= dump_addr_nxt;
    dump_left_r <= dump_left_nxt;
    dump_bwd_r  <= dump_bwd_nxt;
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= DEPTH_CNT)
    else $error("occupancy above depth");

  a_no_take_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP) |-> !in_take)
    else $error("item taken during dump");

  a_held_beat_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP && pend_r && res_hold) |=>
      (pend_r && $stable(dump_left_r) && $stable(dump_addr_r)))
    else $error("held dump beat changed");

  a_write_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> (state_r == S_IDLE && in_take))
    else $error("store write outside an accepted push");
`endif

endmodule

`default_nettype wire

FILE: rtl/double_ended_queue_unit.sv
// top level of the bounded deque: output register around dq_ctrl and dq_store
// depends on dq_pkg, dq_ctrl and dq_store
`timescale 1ns / 1ps
`default_nettype none

// Bounded double-ended queue of dq_pkg::DEPTH 32-bit elements kept in a ring
// buffer inside one synchronous ram with a registered read. One operation per
// input beat: push front, push back, drop front, drop back, dump forward, dump
// backward. Push, drop, an empty dump and an unused code each give one result
// beat, so such items can be accepted every cycle unless out_stall holds a
// beat. A dump of N stored elements gives N beats, the last with final_res
// set, and stalls the input until the last is passed on: a first ram read,
// then one beat per cycle while out_stall is low, paced by the single read
// port of the store. Every result leaves through an output register, and a
// new item is taken while the previous result waits, as long as out_stall
// is low or the register is empty. A push into a full queue reports full and
// changes nothing; a drop from an empty queue reports empty. The store needs
// no clearing after reset since only entries written by a push are read.
module double_ended_queue_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire dq_pkg::in_beat_t  in_beat,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      dq_pkg::out_beat_t out_beat
);
  import dq_pkg::*;

  logic      res_valid;
  out_beat_t res_beat;
  logic      res_hold;
  mem_req_t  mem_req;
  data_t     mem_rd_data;

  logic      out_valid_r, out_valid_nxt;
  out_beat_t out_beat_r;

  // output register is blocked only while it holds a beat that is stalled
  assign res_hold = out_valid_r && out_stall;

  dq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_beat     (in_beat),
    .res_valid   (res_valid),
    .res_beat    (res_beat),
    .res_hold    (res_hold),
    .mem_req     (mem_req),
    .mem_rd_data (mem_rd_data)
  );

  dq_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (mem_rd_data)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (!res_hold) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload loads only with a new beat, so a stalled beat stays put
  always_ff @(posedge clk) begin
    if (res_valid && !res_hold) begin
      out_beat_r <= res_beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// self-checking testbench for double_ended_queue_unit: directed and random deque traffic
// keeps its own ring-buffer model of the deque and checks every result beat in order
// depends on dq_pkg and the rtl of double_ended_queue_unit
`timescale 1ns / 1ps

module tb_top;
  import dq_pkg::*;

  // func codes the block does not use, answered with a plain ok beat
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  localparam int MAX_SHOWN = 10;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_beat;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_beat;

  double_ended_queue_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  // 10 ns clock
  always #5 clk = ~clk;

  // shadow copy of the deque
  data_t ring [DEPTH];
  idx_t  head;
  cnt_t  fill;

  // result beats still owed by the block, oldest first
  out_beat_t pending_beats[$];
  out_beat_t oldest_beat;

  // idling switches, changed per test phase
  bit in_idle_on;
  bit out_idle_on;

  int mismatches;
  int ops_sent;
  int beats_seen;
  int pushes;
  int refused_pushes;
  int drops;
  int empty_drops;
  int dumps;
  int spare_ops;
  int peak_fill;

  function automatic void add_pending(data_t elem, logic [1:0] stat, logic last);
    out_beat_t b;
    b.element   = elem;
    b.status    = stat;
    b.final_res = last;
    pending_beats.push_back(b);
  endfunction

  // advance the shadow deque by one accepted beat and queue the results it owes
  function automatic void model_deque(in_beat_t b);
    int slot;
    int pos;
    ops_sent++;
    case (b.func)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        pushes++;
        if (fill == DEPTH_CNT) begin
          // full: refused, nothing moves
          refused_pushes++;
          add_pending('0, STAT_FULL, 1'b1);
        end else begin
          if (b.func == OP_PUSH_FRONT) begin
            // front steps back one slot, wrapping below zero
            head = idx_t'((int'(head) + DEPTH - 1) % DEPTH);
            slot = int'(head);
          end else begin
            slot = (int'(head) + int'(fill)) % DEPTH;
          end
          ring[slot] = b.value;
          fill       = fill + cnt_t'(1);
          if (int'(fill) > peak_fill) peak_fill = int'(fill);
          add_pending('0, STAT_OK, 1'b1);
        end
      end
      OP_DROP_FRONT, OP_DROP_BACK: begin
        drops++;
        if (fill == '0) begin
          empty_drops++;
          add_pending('0, STAT_EMPTY, 1'b1);
        end else begin
          // head only moves on a front drop; an emptied deque keeps its head
          if (b.func == OP_DROP_FRONT) head = idx_t'((int'(head) + 1) % DEPTH);
          fill = fill - cnt_t'(1);
          add_pending('0, STAT_OK, 1'b1);
        end
      end
      OP_DUMP_FWD, OP_DUMP_BWD: begin
        dumps++;
        if (fill == '0) begin
          add_pending('0, STAT_EMPTY, 1'b1);
        end else begin
          for (int k = 0; k < int'(fill); k++) begin
            pos  = (b.func == OP_DUMP_FWD) ? k : int'(fill) - 1 - k;
            slot = (int'(head) + pos) % DEPTH;
            add_pending(ring[slot], STAT_OK, k == int'(fill) - 1);
          end
        end
      end
      default: begin
        spare_ops++;
        add_pending('0, STAT_OK, 1'b1);
      end
    endcase
  endfunction

  // drive one beat at the falling edge, hold it until taken, then model it
  task automatic send_op(input logic [2:0] f, input data_t v);
    if (in_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= '{func: f, value: v};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model_deque('{func: f, value: v});
    @(negedge clk);
  endtask

  function automatic data_t pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return data_t'($urandom_range(0, 20)) - 32'd10;
      default: return $urandom();
    endcase
  endfunction

  // checker: every beat taken from the block is matched against the oldest owed beat
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      beats_seen++;
      if (pending_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("%0t unexpected beat: element %0d status %0d final %0b",
                   $time, out_beat.element, out_beat.status, out_beat.final_res);
        end
      end else begin
        oldest_beat = pending_beats.pop_front();
        if (out_beat.element !== oldest_beat.element ||
            out_beat.status !== oldest_beat.status ||
            out_beat.final_res !== oldest_beat.final_res) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("%0t mismatch: want element %0d status %0d final %0b, got %0d %0d %0b",
                     $time, oldest_beat.element, oldest_beat.status, oldest_beat.final_res,
                     out_beat.element, out_beat.status, out_beat.final_res);
          end
        end
      end
    end
  end

  // result side back-pressure in random bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (out_idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // every drop and dump on an empty deque, plus the two spare codes
  task automatic test_empty_deque();
    send_op(OP_DROP_FRONT, 32'h1234_5678);
    send_op(OP_DROP_BACK, 32'hffff_ffff);
    send_op(OP_DUMP_FWD, '0);
    send_op(OP_DUMP_BWD, '0);
    send_op(OP_SPARE_6, 32'h8000_0000);
    send_op(OP_SPARE_7, 32'h7fff_ffff);
  endtask

  // alternate front and back pushes up to full, then try one more on each end
  task automatic test_fill_to_full();
    data_t v;
    for (int i = 0; i < DEPTH; i++) begin
      case (i)
        0:       v = 32'h7fff_ffff;
        1:       v = 32'h8000_0000;
        2:       v = 32'h0000_0000;
        3:       v = 32'hffff_ffff;
        4:       v = 32'h5555_5555;
        5:       v = 32'haaaa_aaaa;
        default: v = $urandom();
      endcase
      send_op((i % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK, v);
    end
    send_op(OP_PUSH_FRONT, 32'hdead_beef);
    send_op(OP_PUSH_BACK, 32'h0bad_f00d);
  endtask

  // full-length dumps in both directions
  task automatic test_dump_both_ways();
    send_op(OP_DUMP_FWD, $urandom());
    send_op(OP_DUMP_BWD, $urandom());
  endtask

  // random mix; push_pct steers the fill level up or down
  task automatic test_random_mix(input int n_ops, input int push_pct);
    int roll;
    logic [2:0] f;
    for (int i = 0; i < n_ops; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        f = (roll == 0) ? OP_SPARE_6 : OP_SPARE_7;
      end else if (roll < 16) begin
        f = $urandom_range(0, 1) ? OP_DUMP_FWD : OP_DUMP_BWD;
      end else if ($urandom_range(0, 99) < push_pct) begin
        f = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      end else begin
        f = $urandom_range(0, 1) ? OP_DROP_FRONT : OP_DROP_BACK;
      end
      send_op(f, pick_value());
    end
  endtask

  // fixed limit, well above the slowest legal run
  initial begin
    #10_000_000;
    $display("timeout with %0d beats still owed", pending_beats.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_beat     = '0;
    head        = '0;
    fill        = '0;
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_deque();
    test_fill_to_full();
    test_dump_both_ways();

    // start full, so drain first, then swing the fill level up and down
    test_random_mix(60, 25);
    test_random_mix(60, 75);
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    test_random_mix(50, 55);
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    test_random_mix(60, 30);
    test_random_mix(60, 70);
    // closing stretch runs at full rate on both sides
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    test_random_mix(60, 50);

    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    // a late spurious beat would show up within a dump's length
    repeat (DEPTH + 8) @(posedge clk);

    $display("ops %0d: pushes %0d (%0d refused), drops %0d (%0d on empty), dumps %0d, spare %0d",
             ops_sent, pushes, refused_pushes, drops, empty_drops, dumps, spare_ops);
    $display("result beats checked %0d, peak fill %0d, mismatches %0d",
             beats_seen, peak_fill, mismatches);
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
